[hdl/clamped_cubic_spline_eval_unit_macros.svh]
// Assertion helpers for the spline evaluator
`ifndef CLAMPED_CUBIC_SPLINE_EVAL_UNIT_MACROS_SVH
`define CLAMPED_CUBIC_SPLINE_EVAL_UNIT_MACROS_SVH

// same-cycle implication
`define CCSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ccse_pkg.sv]
package ccse_pkg;

    localparam int MAX_KNOTS = 64;
    localparam int IDX_W     = $clog2(MAX_KNOTS);
    localparam int CNT_W     = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [1:0] ST_INTERP   = 2'd0;
    localparam logic [1:0] ST_CLAMP_LO = 2'd1;
    localparam logic [1:0] ST_CLAMP_HI = 2'd2;
    localparam logic [1:0] ST_DUP      = 2'd3;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic               command;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic signed [31:0] knot_curvature;
        logic signed [31:0] query_x;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         result_status;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] c;
    } knot_t;

endpackage

[hdl/clamped_cubic_spline_eval_unit.sv]
// Clamped cubic spline evaluator. A write item stores one knot (x, y, second derivative) in a
// 64-entry table and gives no result. An evaluate item gives one result. A query below the first
// knot is settled once the first knot has been read, and a query above the last knot once the
// last knot has been read, with no search. An interpolated query goes through the table reads
// of the binary search (one synchronous memory port, up to 6 probes), a 30-step divider
// that forms the interpolation fraction, and 13 steps on one shared multiplier. Two of those
// steps are a reciprocal multiply that divides the curvature term by 6. One item is in work at
// a time; a new item is taken while the last result waits in the output register. Write
// knot_count on cfg_we only while the block is idle.
module clamped_cubic_spline_eval_unit
    import ccse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

`include "clamped_cubic_spline_eval_unit_macros.svh"

    localparam logic [5:0]  DIVA_STEPS = 6'd30;
    localparam logic [31:0] RECIP6     = 32'hAAAA_AAAB;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK0, S_CHKN, S_SRCH, S_RDLO, S_RDHI, S_DIVA, S_AB,
        S_MA2, S_MA3, S_MB2, S_MB3, S_MLY0, S_MLY1, S_MT0, S_MT1,
        S_MDD, S_MP0, S_MP1, S_PSUM, S_D6H, S_D6Q, S_D6L, S_D6E, S_SUM, S_FIN
    } state_t;

    state_t state_reg;

    knot_t knot_mem [MAX_KNOTS];
    knot_t mem_q;
    logic [IDX_W-1:0] rd_addr;
    logic mem_we;

    logic [CNT_W-1:0] knot_count_reg;
    logic [IDX_W-1:0] n_last;

    logic signed [31:0] query_reg;
    logic [IDX_W-1:0] lo_reg, hi_reg, mid_reg;
    logic signed [31:0] xlo_reg, ylo_reg, clo_reg, yhi_reg, chi_reg;
    logic [32:0] adx_reg;
    logic [30:0] a_reg, b_reg;
    logic signed [31:0] ca_reg, cb_reg;
    logic signed [64:0] acc_reg, lin_reg;
    logic signed [34:0] t16_reg;
    logic [48:0] dd_reg;
    logic ovf_reg;

    logic [32:0] rem_reg, div_reg;
    logic [47:0] dvd_reg;
    logic [5:0] cnt_reg;

    logic signed [33:0] mul_x, mul_y;
    logic signed [67:0] prod_reg;

    out_item_t res_reg;
    out_item_t out_item_reg;
    logic out_valid_reg;

    // search
    logic go_hi;
    logic [IDX_W-1:0] lo_nx, hi_nx, mid_nx, span_nx;

    // divider step
    logic [33:0] r2;
    logic ge;
    logic [32:0] rem_nx;
    logic [47:0] dvd_nx;

    // divide by 6
    logic [23:0] q6_c;
    logic [26:0] r6_c;

    // operand and result helpers
    logic signed [32:0] dx_c, u_c;
    logic [32:0] adx_c, absu_c;
    logic wrong_sign;
    logic [30:0] f_hi;
    logic signed [31:0] coef_c;
    logic signed [64:0] t_sum;
    logic [33:0] m_c;
    logic [82:0] p_c;
    logic signed [34:0] linf;
    logic signed [49:0] curv_c, total_c;
    logic [30:0] a_div;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign mem_we    = in_valid && in_ready && (in_item.command == CMD_WRITE);

    always_comb
    begin
        if (knot_count_reg < CNT_W'(2))
        begin
            n_last = IDX_W'(1);
        end
        else if (knot_count_reg > CNT_W'(MAX_KNOTS))
        begin
            n_last = IDX_W'(MAX_KNOTS - 1);
        end
        else
        begin
            n_last = IDX_W'(knot_count_reg - CNT_W'(1));
        end
    end

    always_comb
    begin
        go_hi   = mem_q.x > query_reg;
        lo_nx   = go_hi ? lo_reg : mid_reg;
        hi_nx   = go_hi ? mid_reg : hi_reg;
        span_nx = hi_nx - lo_nx;
        mid_nx  = IDX_W'(({1'b0, lo_nx} + {1'b0, hi_nx}) >> 1);
    end

    always_comb
    begin
        unique case (state_reg)
            S_CHK0:  rd_addr = hi_reg;
            S_CHKN:  rd_addr = (hi_reg > IDX_W'(1)) ? (hi_reg >> 1) : '0;
            S_SRCH:  rd_addr = (span_nx > IDX_W'(1)) ? mid_nx : lo_nx;
            S_RDLO:  rd_addr = hi_reg;
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            knot_mem[in_item.knot_index] <= '{x: in_item.knot_x, y: in_item.knot_y,
                                              c: in_item.knot_curvature};
        end
        mem_q <= knot_mem[rd_addr];
    end

    always_comb
    begin
        r2     = {rem_reg, dvd_reg[47]};
        ge     = r2 >= {1'b0, div_reg};
        rem_nx = ge ? 33'(r2 - {1'b0, div_reg}) : 33'(r2);
        dvd_nx = {dvd_reg[46:0], ge};
    end

    always_comb
    begin
        q6_c = prod_reg[57:34];
        r6_c = {3'b0, dvd_reg[47:24]}
             - ({1'b0, rem_reg[23:0], 2'b0} + {2'b0, rem_reg[23:0], 1'b0});
    end

    always_comb
    begin
        dx_c       = 33'(mem_q.x) - 33'(xlo_reg);
        u_c        = 33'(mem_q.x) - 33'(query_reg);
        adx_c      = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
        absu_c     = u_c[32] ? 33'(-u_c) : 33'(u_c);
        wrong_sign = (u_c != '0) && (u_c[32] != dx_c[32]);
        f_hi       = prod_reg[60:30];
        coef_c     = $signed({1'b0, f_hi}) - $signed({1'b0, (state_reg == S_MB2) ? a_reg : b_reg});
        t_sum      = acc_reg + $signed(prod_reg[64:0]);
        m_c        = t16_reg[34] ? 34'(-t16_reg) : 34'(t16_reg);
        p_c        = 83'(acc_reg[63:0]) + (83'(prod_reg[49:0]) << 32);
        linf       = 35'(lin_reg >>> 30);
        curv_c     = t16_reg[34] ? -$signed({2'b0, dvd_reg}) : $signed({2'b0, dvd_reg});
        total_c    = 50'(linf) + curv_c;
        a_div      = {1'b0, dvd_reg[29:0]};
    end

    always_comb
    begin
        unique case (state_reg)
            S_MA2:   begin mul_x = $signed({3'b0, a_reg}); mul_y = $signed({3'b0, a_reg}); end
            S_MA3:   begin mul_x = $signed({3'b0, f_hi});  mul_y = $signed({3'b0, a_reg}); end
            S_MB2:   begin mul_x = $signed({3'b0, b_reg}); mul_y = $signed({3'b0, b_reg}); end
            S_MB3:   begin mul_x = $signed({3'b0, f_hi});  mul_y = $signed({3'b0, b_reg}); end
            S_MLY0:  begin mul_x = $signed({3'b0, a_reg}); mul_y = 34'(ylo_reg); end
            S_MLY1:  begin mul_x = $signed({3'b0, b_reg}); mul_y = 34'(yhi_reg); end
            S_MT0:   begin mul_x = 34'(ca_reg); mul_y = 34'(clo_reg); end
            S_MT1:   begin mul_x = 34'(cb_reg); mul_y = 34'(chi_reg); end
            S_MDD:   begin mul_x = $signed({1'b0, adx_reg}); mul_y = $signed({1'b0, adx_reg}); end
            S_MP0:   begin mul_x = $signed({1'b0, m_c[32:0]}); mul_y = $signed({2'b0, prod_reg[47:16]}); end
            S_MP1:   begin mul_x = $signed({1'b0, m_c[32:0]}); mul_y = $signed({17'b0, dd_reg[48:32]}); end
            S_D6H:   begin mul_x = $signed({10'b0, dvd_reg[47:24]}); mul_y = $signed({2'b0, RECIP6}); end
            S_D6L:
            begin
                mul_x = $signed({7'b0, r6_c[2:0], dvd_reg[23:0]});
                mul_y = $signed({2'b0, RECIP6});
            end
            default: begin mul_x = '0; mul_y = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_x * mul_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg <= CNT_W'(2);
        end
        else if (cfg_we)
        begin
            knot_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (state_reg == S_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_item.command == CMD_EVAL)
                    begin
                        query_reg <= in_item.query_x;
                        hi_reg    <= n_last;
                        state_reg <= S_CHK0;
                    end
                end
                S_CHK0:
                begin
                    if (query_reg < mem_q.x)
                    begin
                        res_reg   <= '{result_value: mem_q.y, result_status: ST_CLAMP_LO};
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_CHKN;
                    end
                end
                S_CHKN:
                begin
                    lo_reg <= '0;
                    if (query_reg > mem_q.x)
                    begin
                        res_reg   <= '{result_value: mem_q.y, result_status: ST_CLAMP_HI};
                        state_reg <= S_FIN;
                    end
                    else if (hi_reg > IDX_W'(1))
                    begin
                        mid_reg   <= hi_reg >> 1;
                        state_reg <= S_SRCH;
                    end
                    else
                    begin
                        state_reg <= S_RDLO;
                    end
                end
                S_SRCH:
                begin
                    lo_reg  <= lo_nx;
                    hi_reg  <= hi_nx;
                    mid_reg <= mid_nx;
                    if (span_nx <= IDX_W'(1))
                    begin
                        state_reg <= S_RDLO;
                    end
                end
                S_RDLO:
                begin
                    xlo_reg   <= mem_q.x;
                    ylo_reg   <= mem_q.y;
                    clo_reg   <= mem_q.c;
                    state_reg <= S_RDHI;
                end
                S_RDHI:
                begin
                    yhi_reg <= mem_q.y;
                    chi_reg <= mem_q.c;
                    adx_reg <= adx_c;
                    priority if (dx_c == '0)
                    begin
                        res_reg   <= '{result_value: '0, result_status: ST_DUP};
                        state_reg <= S_FIN;
                    end
                    else if (wrong_sign)
                    begin
                        a_reg     <= '0;
                        b_reg     <= ONE_Q30;
                        state_reg <= S_MA2;
                    end
                    else if (absu_c >= adx_c)
                    begin
                        a_reg     <= ONE_Q30;
                        b_reg     <= '0;
                        state_reg <= S_MA2;
                    end
                    else
                    begin
                        rem_reg   <= absu_c;
                        dvd_reg   <= '0;
                        div_reg   <= adx_c;
                        cnt_reg   <= DIVA_STEPS;
                        state_reg <= S_DIVA;
                    end
                end
                S_DIVA:
                begin
                    rem_reg <= rem_nx;
                    dvd_reg <= dvd_nx;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_AB;
                    end
                end
                S_AB:
                begin
                    a_reg     <= a_div;
                    b_reg     <= ONE_Q30 - a_div;
                    state_reg <= S_MA2;
                end
                S_MA2:  state_reg <= S_MA3;
                S_MA3:  state_reg <= S_MB2;
                S_MB2:
                begin
                    ca_reg    <= coef_c;
                    state_reg <= S_MB3;
                end
                S_MB3:  state_reg <= S_MLY0;
                S_MLY0:
                begin
                    cb_reg    <= coef_c;
                    state_reg <= S_MLY1;
                end
                S_MLY1:
                begin
                    acc_reg   <= $signed(prod_reg[64:0]);
                    state_reg <= S_MT0;
                end
                S_MT0:
                begin
                    lin_reg   <= t_sum;
                    state_reg <= S_MT1;
                end
                S_MT1:
                begin
                    acc_reg   <= $signed(prod_reg[64:0]);
                    state_reg <= S_MDD;
                end
                S_MDD:
                begin
                    t16_reg   <= 35'(t_sum >>> 30);
                    state_reg <= S_MP0;
                end
                S_MP0:
                begin
                    dd_reg    <= prod_reg[64:16];
                    state_reg <= S_MP1;
                end
                S_MP1:
                begin
                    acc_reg   <= $signed(prod_reg[64:0]);
                    state_reg <= S_PSUM;
                end
                S_PSUM:
                begin
                    ovf_reg   <= |p_c[82:64];
                    dvd_reg   <= p_c[63:16];
                    state_reg <= S_D6H;
                end
                S_D6H:  state_reg <= S_D6Q;
                S_D6Q:
                begin
                    rem_reg   <= 33'(q6_c);
                    state_reg <= S_D6L;
                end
                S_D6L:  state_reg <= S_D6E;
                S_D6E:
                begin
                    dvd_reg   <= {rem_reg[23:0], q6_c};
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    res_reg.result_status <= ST_INTERP;
                    priority if (ovf_reg)
                    begin
                        res_reg.result_value <= t16_reg[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else if (total_c[49:31] != {19{total_c[49]}})
                    begin
                        res_reg.result_value <= total_c[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    else
                    begin
                        res_reg.result_value <= total_c[31:0];
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_item_reg  <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `CCSE_ASSERT_NOW(a_dup_zero, out_valid && out_item.result_status == ST_DUP, out_item.result_value == '0, "duplicate item with nonzero value")
    `CCSE_ASSERT_NOW(a_search_order, state_reg == S_SRCH, lo_reg < mid_reg && mid_reg < hi_reg, "search bounds out of order")
    `CCSE_ASSERT_NOW(a_div_count, state_reg == S_DIVA, cnt_reg != '0, "divider count exhausted")
    `CCSE_ASSERT_NOW(a_frac_sum, state_reg == S_MA2, 32'(a_reg) + 32'(b_reg) == 32'(ONE_Q30), "fractions do not sum to one")

endmodule
